// ----- src/espd_pkg.sv -----
// Shared types and constants for the escaped size-prefix decoder.
package espd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THIRD_LIMIT  = 2'd2;

    localparam logic [7:0]  ESCAPE_BYTE_RST  = 8'hFF;
    localparam logic [15:0] SECOND_LIMIT_RST = 16'hFFFF;
    localparam logic [23:0] THIRD_LIMIT_RST  = 24'hFF_FFFF;

    // Phase of the prefix: first byte, then 2-, 3- and 4-byte extensions.
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_EXT2  = 2'd1,
        PH_EXT3  = 2'd2,
        PH_EXT4  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  escape_byte;
        logic [15:0] second_limit;
        logic [23:0] third_limit;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  bytes_in_phase;
        logic [31:0] ext_accum;
        logic [31:0] running_size;
        logic [3:0]  bytes_consumed;
    } state_t;

    typedef struct packed {
        logic        emit;
        logic [31:0] size_value;
        logic [3:0]  prefix_length;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        phase:          PH_FIRST,
        bytes_in_phase: 2'd0,
        ext_accum:      32'd0,
        running_size:   32'd0,
        bytes_consumed: 4'd0
    };

endpackage

// ----- src/espd_cfg_regs.sv -----
// Configuration register file: escape byte and the two extension limits.
module espd_cfg_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [espd_pkg::CFG_INDEX_W-1:0]       wr_index,
    input  logic [espd_pkg::CFG_DATA_W-1:0]        wr_data,
    output espd_pkg::cfg_t                         cfg
);
    import espd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ESCAPE_BYTE:  cfg_next.escape_byte  = wr_data[7:0];
                CFG_SECOND_LIMIT: cfg_next.second_limit = wr_data[15:0];
                CFG_THIRD_LIMIT:  cfg_next.third_limit  = wr_data[23:0];
                default:          cfg_next = cfg_reg;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_byte  <= ESCAPE_BYTE_RST;
            cfg_reg.second_limit <= SECOND_LIMIT_RST;
            cfg_reg.third_limit  <= THIRD_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/espd_step.sv -----
// Per-byte decode step: next prefix state and optional result.
module espd_step (
    input  espd_pkg::state_t   state,
    input  espd_pkg::cfg_t     cfg,
    input  logic [7:0]         in_byte,
    output espd_pkg::state_t   state_next,
    output espd_pkg::result_t  result
);
    import espd_pkg::*;

    logic [31:0] acc_shift;
    logic [31:0] sum;
    logic [31:0] limit;
    logic [3:0]  consumed_inc;
    logic [2:0]  count;
    logic [2:0]  need;

    assign acc_shift    = {state.ext_accum[23:0], in_byte};
    assign sum          = state.running_size + acc_shift;
    assign consumed_inc = state.bytes_consumed + 4'd1;
    assign count        = {1'b0, state.bytes_in_phase} + 3'd1;
    assign need         = {1'b0, state.phase} + 3'd1;
    assign limit        = (state.phase == PH_EXT2) ? {16'd0, cfg.second_limit}
                                                   : {8'd0, cfg.third_limit};

    always_comb
    begin
        state_next = state;
        result     = '{emit: 1'b0, size_value: sum, prefix_length: consumed_inc};

        if (state.phase == PH_FIRST)
        begin
            if (in_byte == cfg.escape_byte)
            begin
                state_next                = STATE_CLEAR;
                state_next.phase          = PH_EXT2;
                state_next.running_size   = {24'd0, in_byte};
                state_next.bytes_consumed = 4'd1;
            end
            else
            begin
                result     = '{emit: 1'b1, size_value: {24'd0, in_byte},
                               prefix_length: 4'd1};
                state_next = STATE_CLEAR;
            end
        end
        else if (count < need)
        begin
            // still gathering this extension
            state_next.bytes_in_phase = count[1:0];
            state_next.ext_accum      = acc_shift;
            state_next.bytes_consumed = consumed_inc;
        end
        else if (state.phase != PH_EXT4 && acc_shift == limit)
        begin
            // extension hit its limit: a longer one follows
            state_next.phase          = phase_t'(state.phase + 2'd1);
            state_next.bytes_in_phase = 2'd0;
            state_next.ext_accum      = 32'd0;
            state_next.running_size   = sum;
            state_next.bytes_consumed = consumed_inc;
        end
        else
        begin
            result.emit = 1'b1;
            state_next  = STATE_CLEAR;
        end
    end

endmodule

// ----- src/escaped_size_prefix_decoder_unit.sv -----
// Top level of the escaped size-prefix decoder.
// The result beat follows in the cycle after the beat carrying the last prefix byte.
// Throughput: one input byte per cycle; the prefix state register feeds back
// through a single decode step, which sets that figure.
// Input stalls only while a result sits in the output register untaken.
// Reset (rst_n, async, active low) clears the prefix state and the output
// valid, and restores the escape byte and both limits to all ones.
module escaped_size_prefix_decoder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input byte channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           in_byte,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [31:0]                          size_value,
    output logic [3:0]                           prefix_length,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [espd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [espd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import espd_pkg::*;

    cfg_t        cfg;
    state_t      state_reg;
    state_t      state_next;
    result_t     step_result;
    logic        in_fire;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] size_reg;
    logic [3:0]  length_reg;

    // Config writes are always taken; the user makes a write only while idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;

    espd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Decode step works straight off the prefix state and the incoming byte.
    espd_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .in_byte    (in_byte),
        .state_next (state_next),
        .result     (step_result)
    );

    // Accept whenever the output stage is empty or is draining this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire && step_result.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; loaded only when a prefix completes
    always_ff @(posedge clk)
    begin
        if (in_fire && step_result.emit)
        begin
            size_reg   <= step_result.size_value;
            length_reg <= step_result.prefix_length;
        end
    end

    assign out_valid     = out_valid_reg;
    assign size_value    = size_reg;
    assign prefix_length = length_reg;

    // A delivered prefix is always 1, 3, 6 or 10 bytes long.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (length_reg == 4'd1 || length_reg == 4'd3 ||
                           length_reg == 4'd6 || length_reg == 4'd10))
        else $error("bad prefix length");

    // A one-byte prefix carries that byte alone as its size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && length_reg == 4'd1) |-> (size_reg[31:8] == 24'd0))
        else $error("one-byte prefix with wide size");

    // Waiting for a first byte means nothing of a prefix is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_FIRST) |->
            (state_reg.bytes_consumed == 4'd0 && state_reg.ext_accum == 32'd0 &&
             state_reg.bytes_in_phase == 2'd0))
        else $error("stale prefix state in first phase");

    // Bytes gathered in an extension never reach its full width.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != PH_FIRST) |->
            (state_reg.bytes_in_phase <= state_reg.phase))
        else $error("extension byte count overrun");

    // Backpressure only comes from a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with empty output stage");

endmodule

// ----- tb/tb_escaped_size_prefix_decoder_unit.sv -----
// Self-checking testbench for the escaped size-prefix decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb_escaped_size_prefix_decoder_unit;

    import espd_pkg::*;

    // Register index that maps to nothing; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Idle beats after the last result before a register write is allowed. The block
    // registers each result, so quiet edges with nothing outstanding mean it has settled.
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PCT     = 22;
    localparam int RANDOM_BYTES = 700;

    // One entry of the stimulus plan: either a byte beat or a register write.
    typedef struct {
        logic                   is_reg;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } plan_op_t;

    // One decoded size as the block should report it.
    typedef struct {
        logic [31:0] total;
        logic [3:0]  nbytes;
    } size_rec_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte   = 8'd0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [31:0]            size_value;
    logic [3:0]             prefix_length;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    escaped_size_prefix_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .size_value    (size_value),
        .prefix_length (prefix_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    plan_op_t  byte_plan[$];     // beats still to be driven, in order
    size_rec_t awaited[$];       // decoded sizes not yet seen on the result port
    int        errors = 0;

    // Handshake bookkeeping shared between monitor and driver.
    logic in_took  = 1'b0;       // input beat completed at the last rising edge
    logic cfg_took = 1'b0;       // register write completed at the last rising edge
    int   quiet_cycles = 0;      // edges with no traffic and nothing outstanding

    // ------------------------------------------------------------------
    // Predictor: its own copy of the registers and of the prefix state.
    // ------------------------------------------------------------------
    logic [7:0]  esc_cfg;
    logic [15:0] lim2_cfg;
    logic [23:0] lim3_cfg;
    phase_t      pfx_phase;
    logic [1:0]  ext_count;      // extension bytes seen in the current phase
    logic [31:0] ext_value;      // big-endian extension gathered so far
    logic [31:0] size_sum;       // running size, wraps at 2^32
    logic [3:0]  taken;          // prefix bytes consumed so far

    task automatic clear_prefix_state();
        pfx_phase = PH_FIRST;
        ext_count = 2'd0;
        ext_value = 32'd0;
        size_sum  = 32'd0;
        taken     = 4'd0;
    endtask

    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_ESCAPE_BYTE:  esc_cfg  = d[7:0];
            CFG_SECOND_LIMIT: lim2_cfg = d[15:0];
            CFG_THIRD_LIMIT:  lim3_cfg = d[23:0];
            default: ;
        endcase
    endtask

    // Advances the prefix state by one byte; done is set when a prefix completes.
    task automatic decode_prefix_byte(input logic [7:0] b, output logic done,
                                      output size_rec_t rec);
        logic [31:0] limit;
        done       = 1'b0;
        rec.total  = 32'd0;
        rec.nbytes = 4'd0;
        if (pfx_phase == PH_FIRST) begin
            if (b == esc_cfg) begin
                // escape: the byte itself seeds the size, 2-byte extension follows
                size_sum  = {24'd0, b};
                taken     = 4'd1;
                ext_count = 2'd0;
                ext_value = 32'd0;
                pfx_phase = PH_EXT2;
            end
            else begin
                // any other value, above or below the escape, is the size itself
                done       = 1'b1;
                rec.total  = {24'd0, b};
                rec.nbytes = 4'd1;
                clear_prefix_state();
            end
        end
        else begin
            taken     = taken + 4'd1;
            ext_value = {ext_value[23:0], b};
            // phase n needs n+1 bytes, so more are due while the count is below n
            if (ext_count < pfx_phase) begin
                ext_count = ext_count + 2'd1;
            end
            else begin
                size_sum = size_sum + ext_value;
                limit    = (pfx_phase == PH_EXT2) ? {16'd0, lim2_cfg} : {8'd0, lim3_cfg};
                if (pfx_phase != PH_EXT4 && ext_value == limit) begin
                    pfx_phase = phase_t'(pfx_phase + 2'd1);
                    ext_count = 2'd0;
                    ext_value = 32'd0;
                end
                else begin
                    done       = 1'b1;
                    rec.total  = size_sum;
                    rec.nbytes = taken;
                    clear_prefix_state();
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples every handshake at the rising edge. The result port is
    // checked before a new input beat is predicted, so a size completed at this
    // edge can never be matched against a result that left earlier.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        logic      got;
        size_rec_t rec;
        size_rec_t want;
        if (rst_n) begin
            in_took  <= in_valid && in_ready;
            cfg_took <= cfg_valid && cfg_ready;

            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);

            if (out_valid && out_ready) begin
                if (awaited.size() == 0) begin
                    report_mismatch($sformatf("unexpected result size=%0d length=%0d",
                                              size_value, prefix_length));
                end
                else begin
                    want = awaited.pop_front();
                    if (size_value !== want.total)
                        report_mismatch($sformatf("size_value %0d, expected %0d",
                                                  size_value, want.total));
                    if (prefix_length !== want.nbytes)
                        report_mismatch($sformatf("prefix_length %0d, expected %0d",
                                                  prefix_length, want.nbytes));
                end
            end

            if (in_valid && in_ready) begin
                decode_prefix_byte(in_byte, got, rec);
                if (got)
                    awaited.push_back(rec);
            end

            if ((in_valid && in_ready) || (out_valid && out_ready) || awaited.size() != 0)
                quiet_cycles <= 0;
            else if (quiet_cycles < 64)
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver: works through the plan at the falling edge. Each signal gets a
    // single assignment per edge; a beat is only retired once the monitor has
    // seen its handshake. Register writes hold back until the block is quiet.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : driver
        plan_op_t op;
        logic     in_busy;
        logic     cfg_busy;
        logic     go_in;
        logic     go_cfg;
        logic     steady;
        in_busy  = in_valid && !in_took;
        cfg_busy = cfg_valid && !cfg_took;
        go_in    = 1'b0;
        go_cfg   = 1'b0;
        // a stretch in the middle of the run with no idling on either side
        steady   = byte_plan.size() >= 200 && byte_plan.size() <= 350;
        if (rst_n && !in_busy && !cfg_busy && byte_plan.size() != 0) begin
            op = byte_plan[0];
            if (op.is_reg)
                go_cfg = (quiet_cycles >= DRAIN_CYCLES) && !in_valid;
            else
                go_in = steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (go_in || go_cfg)
                void'(byte_plan.pop_front());
        end

        if (go_in) begin
            in_valid <= 1'b1;
            in_byte  <= op.data[7:0];
        end
        else if (!in_busy) begin
            in_valid <= 1'b0;
        end

        if (go_cfg) begin
            cfg_valid <= 1'b1;
            cfg_index <= op.index;
            cfg_data  <= op.data;
        end
        else if (!cfg_busy) begin
            cfg_valid <= 1'b0;
        end

        if (rst_n)
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus planning. The planner tracks the register values that will be
    // live when each byte is driven, so it can build well-formed prefixes.
    // ------------------------------------------------------------------
    logic [7:0]  plan_esc  = ESCAPE_BYTE_RST;
    logic [15:0] plan_lim2 = SECOND_LIMIT_RST;
    logic [23:0] plan_lim3 = THIRD_LIMIT_RST;
    int          planned_bytes = 0;

    task automatic plan_byte(input logic [7:0] b);
        plan_op_t op;
        op.is_reg = 1'b0;
        op.index  = '0;
        op.data   = {16'd0, b};
        byte_plan.push_back(op);
        planned_bytes++;
    endtask

    task automatic plan_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] d);
        plan_op_t op;
        op.is_reg = 1'b1;
        op.index  = idx;
        op.data   = d;
        byte_plan.push_back(op);
        case (idx)
            CFG_ESCAPE_BYTE:  plan_esc  = d[7:0];
            CFG_SECOND_LIMIT: plan_lim2 = d[15:0];
            CFG_THIRD_LIMIT:  plan_lim3 = d[23:0];
            default: ;
        endcase
    endtask

    // Extension of n bytes, most significant first.
    task automatic plan_ext(input int n, input logic [31:0] v);
        for (int i = n - 1; i >= 0; i--)
            plan_byte(v[8*i +: 8]);
    endtask

    // Random extension value of n bytes that, for fewer than 4 bytes, does not hit the given limit,
    // biased towards all zeros and all ones.
    function automatic logic [31:0] pick_ext(input int n, input logic [31:0] limit);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        do begin
            case ($urandom_range(0, 3))
                0:       v = 32'd0;
                1:       v = mask;
                default: v = $urandom & mask;
            endcase
        end while (n < 4 && v == limit);
        return v;
    endfunction

    // Extensions following an escape byte, for a prefix of 3, 6 or 10 bytes.
    task automatic plan_tail(input int len);
        if (len == 3) begin
            plan_ext(2, pick_ext(2, {16'd0, plan_lim2}));
        end
        else begin
            plan_ext(2, {16'd0, plan_lim2});
            if (len == 6) begin
                plan_ext(3, pick_ext(3, {8'd0, plan_lim3}));
            end
            else begin
                plan_ext(3, {8'd0, plan_lim3});
                plan_ext(4, pick_ext(4, 32'd0));
            end
        end
    endtask

    task automatic plan_prefix(input int len);
        logic [7:0] b;
        if (len == 1) begin
            do begin
                case ($urandom_range(0, 3))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end while (b == plan_esc);
            plan_byte(b);
        end
        else begin
            plan_byte(plan_esc);
            plan_tail(len);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      return 1;
        else if (r < 65) return 3;
        else if (r < 85) return 6;
        else             return 10;
    endfunction

    // Register value: the lower extreme, the upper extreme, or anything.
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_DATA_W-1:0] top);
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return top;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // New settings for a random phase; the first one writes every register.
    task automatic plan_settings(input logic all_regs);
        if (all_regs || $urandom_range(0, 99) < 60)
            plan_reg(CFG_ESCAPE_BYTE, pick_reg(24'h0000FF));
        if (all_regs || $urandom_range(0, 99) < 60)
            plan_reg(CFG_SECOND_LIMIT, pick_reg(24'h00FFFF));
        if (all_regs || $urandom_range(0, 99) < 60)
            plan_reg(CFG_THIRD_LIMIT, pick_reg(24'hFFFFFF));
        if ($urandom_range(0, 99) < 10)
            plan_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    initial begin : stimulus
        int  first_random;
        int  target;
        int  n;
        int  waited;
        logic first_phase;

        esc_cfg  = ESCAPE_BYTE_RST;
        lim2_cfg = SECOND_LIMIT_RST;
        lim3_cfg = THIRD_LIMIT_RST;
        clear_prefix_state();

        // --- directed part, starting from the reset register values ---
        plan_byte(8'h00);                   // smallest one-byte size
        plan_byte(8'hFE);                   // largest value below the escape
        plan_byte(8'hFF);                   // escape, short extension
        plan_ext(2, 32'h0000_0005);
        plan_byte(8'hFF);                   // every extension at its limit: sum wraps
        plan_ext(2, 32'h0000_FFFF);
        plan_ext(3, 32'h00FF_FFFF);
        plan_ext(4, 32'hFFFF_FFFF);
        plan_reg(CFG_ESCAPE_BYTE, 24'h000000);
        plan_reg(CFG_SECOND_LIMIT, 24'h000000);
        plan_reg(CFG_THIRD_LIMIT, 24'h000000);
        plan_byte(8'h00);                   // zero escape byte still escapes
        plan_ext(2, 32'h0000_0001);
        plan_reg(CFG_ESCAPE_BYTE, 24'hFFFF80);
        plan_byte(8'hC0);                   // first byte above the escape value
        // limit changed in the middle of a prefix: the old third limit (zero)
        // must no longer call for the 4-byte extension
        plan_byte(8'h80);
        plan_ext(2, 32'h0000_0000);
        plan_reg(CFG_THIRD_LIMIT, 24'h000102);
        plan_ext(3, 32'h0000_0000);

        // --- random part: phases of mostly well-formed prefixes ---
        first_random = planned_bytes;
        first_phase  = 1'b1;
        while (planned_bytes - first_random < RANDOM_BYTES) begin
            if (!first_phase && $urandom_range(0, 99) < 30) begin
                // escape under the old settings, extensions under the new
                plan_byte(plan_esc);
                plan_settings(1'b0);
                plan_tail(3 * $urandom_range(1, 2) + ($urandom_range(0, 1) ? 4 : 0) - 
                          (0));
            end
            else begin
                plan_settings(first_phase);
            end
            first_phase = 1'b0;
            target = planned_bytes + $urandom_range(50, 110);
            while (planned_bytes < target) begin
                if ($urandom_range(0, 99) < 80) begin
                    plan_prefix(pick_len());
                end
                else begin
                    // noise: loose bytes, often the escape, breaking up prefixes
                    n = $urandom_range(1, 4);
                    repeat (n)
                        plan_byte($urandom_range(0, 99) < 30 ? plan_esc
                                                             : 8'($urandom_range(0, 255)));
                end
            end
        end

        // --- reset once, then let the driver run ---
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_plan.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        waited = 0;
        while (awaited.size() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        // a few more edges to catch any stray result beat
        repeat (8) @(posedge clk);
        if (awaited.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", awaited.size()));

        if (errors == 0)
            $display("** escaped_size_prefix_decoder_unit: PASSED **");
        else
            $display("** escaped_size_prefix_decoder_unit: FAILED **");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("** escaped_size_prefix_decoder_unit: FAILED **");
        $finish;
    end

endmodule
